// ===== hw/rtl/vhpc_pkg.sv =====
// Shared types, fixed-point constants and the control program of the voice
// high-pass / presence / compressor block.
// No dependencies; used by vhpc_dp and voice_hpf_presence_compressor.
`default_nettype none

package vhpc_pkg;

  // Datapath widths (Q8.24 signal path, wide working register and product)
  localparam int OPA_W  = 35;
  localparam int COEF_W = 28;
  localparam int PROD_W = 63;
  localparam int PC_W   = 5;

  // Filter and gain coefficients, 16 fraction bits
  localparam logic signed [COEF_W-1:0] CO_ALPHA = 28'sd64857;
  localparam logic signed [COEF_W-1:0] CO_LPK   = 28'sd16384;
  localparam logic signed [COEF_W-1:0] CO_PRES  = 28'sd9175;
  localparam logic signed [COEF_W-1:0] CO_GAIN  = 28'sd164619;
  // ceil(2^28 / 3): exact floor division by three for excess below 2^27
  localparam logic signed [COEF_W-1:0] CO_THIRD = 28'sd89478486;

  // Compressor knee and limiter, Q24
  localparam logic signed [OPA_W-1:0] Q_THRESH = 35'sd2348810;
  localparam logic signed [OPA_W-1:0] Q_LIMIT  = 35'sd14952711;
  // Any excess at or above this value already drives the result into the limit
  localparam logic signed [OPA_W-1:0] EXC_SAT  = 35'sd67108863;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIFF_IN,
    OP_MUL,
    OP_WB_HP,
    OP_DIFF,
    OP_WB_LP,
    OP_LIFT,
    OP_ABS,
    OP_KNEE,
    OP_COMP
  } op_t;

  // Multiplier coefficient select
  typedef enum logic [2:0] {
    CF_ALPHA,
    CF_LPK,
    CF_PRES,
    CF_GAIN,
    CF_THIRD,
    CF_FULL
  } coef_t;

  // Sequencer branch kinds
  typedef enum logic [2:0] {
    J_NEXT,
    J_WAIT_IN,
    J_WAIT_OUT,
    J_KNEE,
    J_GOTO
  } jmp_t;

  typedef struct packed {
    op_t             op;
    coef_t           coef;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    op_t   op;
    coef_t coef;
    logic  load;
  } dp_ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic below_knee;
  } dp_stat_t;

  localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] PC_MUL_FULL = 5'd15;

  // Control store: one word per step
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_NOP, coef: CF_ALPHA, jmp: J_NEXT, target: PC_IDLE};
    case (pc)
      5'd0:  w.jmp = J_WAIT_IN;                          // wait for a sample
      5'd1:  w.op = OP_DIFF_IN;                          // hp + x - x_prev
      5'd2:  begin w.op = OP_MUL; w.coef = CF_ALPHA; end
      5'd3:  w.op = OP_WB_HP;                            // store high-pass
      5'd4:  w.op = OP_DIFF;                             // hp - lp
      5'd5:  begin w.op = OP_MUL; w.coef = CF_LPK; end
      5'd6:  w.op = OP_WB_LP;                            // update low-pass
      5'd7:  w.op = OP_DIFF;                             // hp - lp (new lp)
      5'd8:  begin w.op = OP_MUL; w.coef = CF_PRES; end
      5'd9:  w.op = OP_LIFT;                             // hp + presence
      5'd10: begin w.op = OP_MUL; w.coef = CF_GAIN; end
      5'd11: w.op = OP_ABS;                              // magnitude and sign
      5'd12: begin                                       // skip ratio below knee
        w.op     = OP_KNEE;
        w.jmp    = J_KNEE;
        w.target = PC_MUL_FULL;
      end
      5'd13: begin w.op = OP_MUL; w.coef = CF_THIRD; end
      5'd14: w.op = OP_COMP;                             // knee + excess/3, limit
      5'd15: begin w.op = OP_MUL; w.coef = CF_FULL; end
      5'd16: begin                                       // hand result over
        w.jmp    = J_WAIT_OUT;
        w.target = PC_IDLE;
      end
      default: begin
        w.jmp    = J_GOTO;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vhpc_dp.sv =====
// Datapath of the voice conditioning block: filter state, working registers,
// one shared multiplier and the rounding / compressor logic.
// Depends on vhpc_pkg; driven step by step by voice_hpf_presence_compressor.
`default_nettype none

module vhpc_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire vhpc_pkg::dp_ctrl_t         ctrl,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output vhpc_pkg::dp_stat_t              stat,
  output logic signed [SAMPLE_BITS-1:0]   res
);

  localparam int SHIFT = 25 - SAMPLE_BITS;
  localparam logic signed [vhpc_pkg::COEF_W-1:0] FULL =
    vhpc_pkg::COEF_W'((1 << (SAMPLE_BITS - 1)) - 1);

  // Filter state
  logic signed [SAMPLE_BITS-1:0]      px;
  logic signed [31:0]                 hp;
  logic signed [31:0]                 lp;
  // Working registers
  logic signed [SAMPLE_BITS-1:0]      xin;
  logic signed [vhpc_pkg::OPA_W-1:0]  opa;
  logic signed [vhpc_pkg::PROD_W-1:0] prod;
  logic                               neg;

  logic signed [vhpc_pkg::OPA_W-1:0]  xq;
  logic signed [vhpc_pkg::OPA_W-1:0]  pxq;
  logic signed [vhpc_pkg::COEF_W-1:0] coef;
  logic signed [vhpc_pkg::PROD_W-1:0] rnd_sum;
  logic signed [46:0]                 rp;
  logic [vhpc_pkg::PROD_W-1:0]        abs_sum;
  logic signed [vhpc_pkg::OPA_W-1:0]  exc;
  logic [25:0]                        knee_sum;
  logic [47:0]                        mag_sum;
  logic [SAMPLE_BITS-1:0]             mag;
  logic                               below;

  // Scale samples to Q24
  assign xq  = vhpc_pkg::OPA_W'(xin) <<< SHIFT;
  assign pxq = vhpc_pkg::OPA_W'(px) <<< SHIFT;

  // Coefficient select for the shared multiplier
  always_comb begin
    case (ctrl.coef)
      vhpc_pkg::CF_ALPHA: coef = vhpc_pkg::CO_ALPHA;
      vhpc_pkg::CF_LPK:   coef = vhpc_pkg::CO_LPK;
      vhpc_pkg::CF_PRES:  coef = vhpc_pkg::CO_PRES;
      vhpc_pkg::CF_GAIN:  coef = vhpc_pkg::CO_GAIN;
      vhpc_pkg::CF_THIRD: coef = vhpc_pkg::CO_THIRD;
      vhpc_pkg::CF_FULL:  coef = FULL;
      default:            coef = '0;
    endcase
  end

  // Round product half away from zero to Q24
  assign rnd_sum = prod + (prod[vhpc_pkg::PROD_W-1] ? 63'sd32767 : 63'sd32768);
  assign rp      = rnd_sum[62:16];

  // Magnitude of the rounded product in one add
  assign abs_sum = (prod ^ {vhpc_pkg::PROD_W{prod[vhpc_pkg::PROD_W-1]}})
                 + (prod[vhpc_pkg::PROD_W-1] ? 63'd32769 : 63'd32768);

  // Compressor knee
  assign below    = (opa <= vhpc_pkg::Q_THRESH);
  assign exc      = opa - vhpc_pkg::Q_THRESH;
  assign knee_sum = vhpc_pkg::Q_THRESH[25:0] + 26'(prod[52:28]);
  assign stat.below_knee = below;

  // Final scaling, round half up on the magnitude, restore sign
  assign mag_sum = prod[47:0] + 48'd8388608;
  assign mag     = mag_sum[24 +: SAMPLE_BITS];
  assign res     = neg ? -signed'(mag) : signed'(mag);

  // Filter state: cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      hp <= '0;
      lp <= '0;
    end else begin
      case (ctrl.op)
        vhpc_pkg::OP_DIFF_IN: px <= xin;
        vhpc_pkg::OP_WB_HP:   hp <= vhpc_pkg::sat32(48'(rp));
        vhpc_pkg::OP_WB_LP:   lp <= vhpc_pkg::sat32(48'(lp) + 48'(rp));
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      xin <= sample_in;
    end
    case (ctrl.op)
      vhpc_pkg::OP_DIFF_IN: opa <= vhpc_pkg::OPA_W'(hp) + xq - pxq;
      vhpc_pkg::OP_MUL:     prod <= vhpc_pkg::PROD_W'(opa) * vhpc_pkg::PROD_W'(coef);
      vhpc_pkg::OP_DIFF:    opa <= vhpc_pkg::OPA_W'(hp) - vhpc_pkg::OPA_W'(lp);
      vhpc_pkg::OP_LIFT:    opa <= vhpc_pkg::OPA_W'(hp) + rp[vhpc_pkg::OPA_W-1:0];
      vhpc_pkg::OP_ABS: begin
        neg <= prod[vhpc_pkg::PROD_W-1];
        opa <= signed'(abs_sum[50:16]);
      end
      vhpc_pkg::OP_KNEE: begin
        if (!below) begin
          opa <= (exc > vhpc_pkg::EXC_SAT) ? vhpc_pkg::EXC_SAT : exc;
        end
      end
      vhpc_pkg::OP_COMP: begin
        if (signed'({9'd0, knee_sum}) > vhpc_pkg::Q_LIMIT) begin
          opa <= vhpc_pkg::Q_LIMIT;
        end else begin
          opa <= signed'({9'd0, knee_sum});
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/voice_hpf_presence_compressor.sv =====
// Voice conditioning block: first-order high-pass, presence lift, +8 dB gain,
// 3:1 soft compressor and limiter, rounded back to a signed sample.
//
// Channels: in_valid/in_ready carry sample_in, out_valid/out_ready carry
// sample_out. A transaction completes on a clock edge where valid and ready
// are both high. Each input transaction yields exactly one output.
// One sample is processed at a time. A small control program steps a single
// shared multiplier: the input is accepted at step 0 and the result is
// loaded into the output register at step 16. Samples below the compressor
// knee skip the divide-by-three product. A new sample is taken only after
// the last result has gone to the output register; the multiplier's chain
// of six or five products runs in between. in_ready is high only while the
// program waits at step 0.
// When the receiver stalls, a finished result waits in the output register
// and the program holds at its last step until the register frees up.
// Reset (synchronous) clears the filter state and the output valid flag and
// returns the program to step 0.
`default_nettype none

module voice_hpf_presence_compressor #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]    sample_out
);

  logic [vhpc_pkg::PC_W-1:0]      pc;
  logic [vhpc_pkg::PC_W-1:0]      pc_next;
  vhpc_pkg::ucode_t               uc;
  vhpc_pkg::dp_ctrl_t             ctrl;
  vhpc_pkg::dp_stat_t             stat;
  logic signed [SAMPLE_BITS-1:0]  res;
  logic                           in_fire;
  logic                           out_free;
  logic                           out_load;

  // Fetch the control word of the current step
  assign uc = vhpc_pkg::ucode(pc);

  assign in_ready = (uc.jmp == vhpc_pkg::J_WAIT_IN);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = (uc.jmp == vhpc_pkg::J_WAIT_OUT) && out_free;

  assign ctrl.op   = uc.op;
  assign ctrl.coef = uc.coef;
  assign ctrl.load = in_fire;

  // Next step: advance, hold on a handshake, or branch
  always_comb begin
    case (uc.jmp)
      vhpc_pkg::J_NEXT:     pc_next = pc + 5'd1;
      vhpc_pkg::J_WAIT_IN:  pc_next = in_fire ? pc + 5'd1 : pc;
      vhpc_pkg::J_WAIT_OUT: pc_next = out_free ? uc.target : pc;
      vhpc_pkg::J_KNEE:     pc_next = stat.below_knee ? uc.target : pc + 5'd1;
      vhpc_pkg::J_GOTO:     pc_next = uc.target;
      default:              pc_next = vhpc_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= vhpc_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= res;
    end
  end

  vhpc_dp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sample_in(sample_in),
    .stat     (stat),
    .res      (res)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/vhpc_chk.sv =====
// Port-level checker for voice_hpf_presence_compressor, attached by bind.
// No package dependency; sees only the top level's ports.
`default_nettype none

module vhpc_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [SAMPLE_BITS-1:0]        sample_out
);

  localparam longint FULL = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint LIM  = (longint'(14952711) * FULL + longint'(8388608)) >>> 24;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("output changed while stalled");

  // One sample in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // A new result does not appear while the program waits for input
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while waiting for input");

  // Limiter bounds every result
  a_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> longint'($signed(sample_out)) <= LIM &&
                  longint'($signed(sample_out)) >= -LIM)
    else $error("result beyond limiter bound");

  // Reset empties the output and reopens the input
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("reset did not return to idle");

endmodule

bind voice_hpf_presence_compressor vhpc_chk #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sample_out(sample_out)
);

`default_nettype wire
